/* design/cnf_tok_pkg.sv */
// shared types and codes for the cnf text tokenizer
`default_nettype none
package cnf_tok_pkg;

    localparam logic [1:0] KIND_LITERAL    = 2'd0;
    localparam logic [1:0] KIND_CLAUSE_END = 2'd1;
    localparam logic [1:0] KIND_SUMMARY    = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    localparam logic [2:0] ERR_NONE            = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR        = 3'd0;
    localparam logic [2:0] ERR_BAD_FIELD       = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW        = 3'd2;
    localparam logic [2:0] ERR_NOT_CNF         = 3'd3;
    localparam logic [2:0] ERR_DUP_HEADER      = 3'd4;
    localparam logic [2:0] ERR_OPEN_CLAUSE     = 3'd5;
    localparam logic [2:0] ERR_VAR_MISMATCH    = 3'd6;
    localparam logic [2:0] ERR_CLAUSE_MISMATCH = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] literal;
        logic [30:0] var_total;
        logic [31:0] clause_total;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]          count;
        t_result [1:0]       res;
    } t_step;

endpackage
`default_nettype wire

/* design/cnf_tok_core.sv */
// parse state and per-byte step logic of the cnf text tokenizer
`default_nettype none
module cnf_tok_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire  [7:0]           i_byte,
    output cnf_tok_pkg::t_step   o_step
);

    typedef enum logic [3:0] {
        M_TOP, M_COMMENT, M_P_WS, M_WORD, M_HV_WS, M_HV_FIRST, M_HV_DIGITS,
        M_HC_WS, M_HC_FIRST, M_HC_DIGITS, M_LIT_FIRST, M_LIT_DIGITS
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [2:0]  word_match;
        logic [30:0] magnitude;
        logic        negative;
        logic        clause_open;
        logic [30:0] max_var;
        logic [31:0] clause_counter;
        logic [31:0] header_vars;
        logic [31:0] header_clauses;
        logic        halted;
    } t_parse_state;

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_NL    = 8'h0A;
    localparam logic [7:0]  CH_C     = 8'h63;
    localparam logic [7:0]  CH_N     = 8'h6E;
    localparam logic [7:0]  CH_F     = 8'h66;
    localparam logic [7:0]  CH_P     = 8'h70;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [34:0] MAG_MAX  = 35'h07FFFFFFF;
    localparam logic [31:0] HDR_OFF  = 32'hFFFFFFFF;
    localparam logic [2:0]  WM_DONE  = 3'd3;
    localparam logic [2:0]  WM_BAD   = 3'd4;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic [7:0] cnf_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_C;
            3'd1:    c = CH_N;
            default: c = CH_F;
        endcase
        return c;
    endfunction

    function automatic cnf_tok_pkg::t_result make_res(input t_parse_state s,
                                                      input logic [1:0] kind,
                                                      input logic [31:0] lit,
                                                      input logic [2:0] err);
        cnf_tok_pkg::t_result r;
        r.kind         = kind;
        r.literal      = lit;
        r.var_total    = s.max_var;
        r.clause_total = s.clause_counter;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic cnf_tok_pkg::t_result finish_res(input t_parse_state s);
        cnf_tok_pkg::t_result r;
        if (s.clause_open) begin
            r = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                         cnf_tok_pkg::ERR_OPEN_CLAUSE);
        end else if (s.header_vars != HDR_OFF && s.header_vars != {1'b0, s.max_var}) begin
            r = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                         cnf_tok_pkg::ERR_VAR_MISMATCH);
        end else if (s.header_clauses != HDR_OFF && s.header_clauses != s.clause_counter) begin
            r = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                         cnf_tok_pkg::ERR_CLAUSE_MISMATCH);
        end else begin
            r = make_res(s, cnf_tok_pkg::KIND_SUMMARY, 32'd0, cnf_tok_pkg::ERR_NONE);
        end
        return r;
    endfunction

    t_parse_state r_state;
    t_parse_state n_state;
    cnf_tok_pkg::t_result res [2];
    logic [1:0]   cnt;

    always_comb begin
        t_parse_state s;
        logic         go;
        logic [7:0]   b;
        logic [3:0]   dig;
        logic [34:0]  v;
        logic [31:0]  numval;
        s      = r_state;
        go     = 1'b1;
        cnt    = 2'd0;
        res[0] = '0;
        res[1] = '0;
        b      = i_byte;
        dig    = i_byte[3:0];
        v      = '0;
        numval = '0;
        for (int k = 0; k < 2; k++) begin
            if (go && !s.halted) begin
                go     = 1'b0;
                numval = s.negative ? (32'd0 - {1'b0, s.magnitude}) : {1'b0, s.magnitude};
                v      = ({4'd0, s.magnitude} << 3) + ({4'd0, s.magnitude} << 1)
                         + {31'd0, dig};
                unique case (s.mode) inside
                    M_TOP: begin
                        if (b == CH_NUL) begin
                            res[cnt[0]] = finish_res(s);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end else if (is_space(b)) begin
                        end else if (b == CH_C) begin
                            s.mode = M_COMMENT;
                        end else if (b == CH_P) begin
                            s.mode = M_P_WS;
                        end else if (is_digit(b) || b == CH_MINUS) begin
                            if (b == CH_MINUS) begin
                                s.negative  = 1'b1;
                                s.magnitude = '0;
                                s.mode      = M_LIT_FIRST;
                            end else begin
                                s.negative  = 1'b0;
                                s.magnitude = {27'd0, dig};
                                s.mode      = M_LIT_DIGITS;
                            end
                        end else begin
                            res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                   cnf_tok_pkg::ERR_BAD_CHAR);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (b == CH_NUL) begin
                            res[cnt[0]] = finish_res(s);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end else if (b == CH_NL) begin
                            s.mode = M_TOP;
                        end
                    end
                    M_P_WS: begin
                        if (is_space(b)) begin
                        end else if (is_alpha(b)) begin
                            s.word_match = (b == CH_C) ? 3'd1 : WM_BAD;
                            s.mode       = M_WORD;
                        end else begin
                            res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                   cnf_tok_pkg::ERR_BAD_FIELD);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end
                    end
                    M_WORD: begin
                        if (is_alpha(b)) begin
                            if (s.word_match < WM_DONE && b == cnf_char(s.word_match)) begin
                                s.word_match = s.word_match + 3'd1;
                            end else begin
                                s.word_match = WM_BAD;
                            end
                        end else if (s.word_match != WM_DONE) begin
                            res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                   cnf_tok_pkg::ERR_NOT_CNF);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end else if (s.header_vars != HDR_OFF || s.header_clauses != HDR_OFF) begin
                            res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                   cnf_tok_pkg::ERR_DUP_HEADER);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end else begin
                            s.mode = M_HV_WS;
                            go     = 1'b1;
                        end
                    end
                    M_HV_WS, M_HC_WS: begin
                        if (is_space(b)) begin
                        end else if (is_digit(b) || b == CH_MINUS) begin
                            if (b == CH_MINUS) begin
                                s.negative  = 1'b1;
                                s.magnitude = '0;
                                s.mode      = (s.mode == M_HV_WS) ? M_HV_FIRST : M_HC_FIRST;
                            end else begin
                                s.negative  = 1'b0;
                                s.magnitude = {27'd0, dig};
                                s.mode      = (s.mode == M_HV_WS) ? M_HV_DIGITS : M_HC_DIGITS;
                            end
                        end else begin
                            res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                   cnf_tok_pkg::ERR_BAD_FIELD);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end
                    end
                    M_HV_FIRST, M_HC_FIRST, M_LIT_FIRST: begin
                        if (!is_digit(b)) begin
                            res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                   cnf_tok_pkg::ERR_BAD_FIELD);
                            cnt = cnt + 2'd1;
                            s.halted = 1'b1;
                        end else begin
                            s.magnitude = {27'd0, dig};
                            if (s.mode == M_HV_FIRST) begin
                                s.mode = M_HV_DIGITS;
                            end else if (s.mode == M_HC_FIRST) begin
                                s.mode = M_HC_DIGITS;
                            end else begin
                                s.mode = M_LIT_DIGITS;
                            end
                        end
                    end
                    M_HV_DIGITS, M_HC_DIGITS, M_LIT_DIGITS: begin
                        if (is_digit(b)) begin
                            if (v > MAG_MAX) begin
                                res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_ERROR, 32'd0,
                                                       cnf_tok_pkg::ERR_OVERFLOW);
                                cnt = cnt + 2'd1;
                                s.halted = 1'b1;
                            end else begin
                                s.magnitude = v[30:0];
                            end
                        end else if (s.mode == M_HV_DIGITS) begin
                            s.header_vars = numval;
                            s.mode        = M_HC_WS;
                            go            = 1'b1;
                        end else if (s.mode == M_HC_DIGITS) begin
                            s.header_clauses = numval;
                            s.mode           = M_TOP;
                            go               = 1'b1;
                        end else begin
                            if (s.magnitude == '0) begin
                                s.clause_counter = s.clause_counter + 32'd1;
                                s.clause_open    = 1'b0;
                                res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_CLAUSE_END, 32'd0,
                                                       cnf_tok_pkg::ERR_NONE);
                            end else begin
                                if (s.magnitude > s.max_var) begin
                                    s.max_var = s.magnitude;
                                end
                                s.clause_open = 1'b1;
                                res[cnt[0]] = make_res(s, cnf_tok_pkg::KIND_LITERAL, numval,
                                                       cnf_tok_pkg::ERR_NONE);
                            end
                            cnt    = cnt + 2'd1;
                            s.mode = M_TOP;
                            go     = 1'b1;
                        end
                    end
                    default: begin
                        s.mode = M_TOP;
                        go     = 1'b1;
                    end
                endcase
            end
        end
        if (cnt != 2'd0) begin
            res[1'(cnt - 2'd1)].last = 1'b1;
        end
        n_state = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= M_TOP;
            r_state.word_match     <= '0;
            r_state.magnitude      <= '0;
            r_state.negative       <= 1'b0;
            r_state.clause_open    <= 1'b0;
            r_state.max_var        <= '0;
            r_state.clause_counter <= '0;
            r_state.header_vars    <= HDR_OFF;
            r_state.header_clauses <= HDR_OFF;
            r_state.halted         <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_step.count  = cnt;
    assign o_step.res[0] = res[0];
    assign o_step.res[1] = res[1];

    a_two_results_first_is_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_step.count == 2'd2) |->
        (o_step.res[0].kind == cnf_tok_pkg::KIND_LITERAL ||
         o_step.res[0].kind == cnf_tok_pkg::KIND_CLAUSE_END))
        else $error("two results but first is not a token");

    a_final_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_step.count != 2'd0 &&
         (o_step.res[1'(o_step.count - 2'd1)].kind == cnf_tok_pkg::KIND_ERROR ||
          o_step.res[1'(o_step.count - 2'd1)].kind == cnf_tok_pkg::KIND_SUMMARY))
        |=> r_state.halted)
        else $error("summary or error did not halt the parser");

endmodule
`default_nettype wire

/* design/cnf_tok_fifo.sv */
// result queue taking up to two results per cycle, one out per transaction
`default_nettype none
module cnf_tok_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  cnf_tok_pkg::t_step    i_push,
    input  wire                   i_pop,
    output logic                  o_valid,
    output cnf_tok_pkg::t_result  o_data,
    output logic                  o_room2
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    cnf_tok_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.res[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[next_ptr(r_wptr)] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.count == 2'd1) begin
                r_wptr <= next_ptr(r_wptr);
            end else if (i_push.count == 2'd2) begin
                r_wptr <= next_ptr(next_ptr(r_wptr));
            end
            if (pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            r_count <= r_count + CW'(i_push.count) - CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |->
        (int'(r_count) + int'(i_push.count) - int'(pop) <= DEPTH))
        else $error("result queue overflow");

endmodule
`default_nettype wire

/* design/cnf_text_tokenizer_unit.sv */
// top level of the cnf text tokenizer: input register, parser step, result queue
// path: an accepted byte is held in the input register, parsed when the result
//   queue has room for two results, and its results are then written to the queue
// throughput: one byte per cycle while the result queue has room for two; a byte
//   that gives two results holds the output for two transactions
// reset: synchronous active low; clears parser state, input valid flag and queue
`default_nettype none
module cnf_text_tokenizer_unit #(
    parameter int DEPTH = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  wire  [7:0]    i_s_axis_tdata,   // text_byte[7:0]
    output logic          o_m_axis_tvalid,
    input  wire           i_m_axis_tready,
    output logic [103:0]  o_m_axis_tdata,   // literal[31:0], var_total[62:32],
                                            // clause_total[94:63], error_code[97:95]
    output logic [1:0]    o_m_axis_tuser,   // kind[1:0]
    output logic          o_m_axis_tlast
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 fire;
    logic                 room2;
    cnf_tok_pkg::t_step   step;
    cnf_tok_pkg::t_step   push;
    cnf_tok_pkg::t_result head;

    assign fire            = r_in_valid && room2;
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    cnf_tok_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_step  (step)
    );

    always_comb begin
        push = step;
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    cnf_tok_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (head),
        .o_room2 (room2)
    );

    assign o_m_axis_tdata = {6'd0, head.error_code, head.clause_total, head.var_total,
                             head.literal};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule
`default_nettype wire
